### src/dts_pkg.sv
// Shared types and constants for the driver threshold search unit.
// Holds the phase and outcome codes, request kinds and register indexes.
// No dependencies.
package dts_pkg;

  localparam int OC_W    = 5;
  localparam int STALL_W = 7;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    PH_OC_DOWN    = 3'd0,
    PH_OC_UP      = 3'd1,
    PH_STALL_DOWN = 3'd2,
    PH_STALL_UP   = 3'd3,
    PH_IDLE       = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    OUT_RUNNING     = 3'd0,
    OUT_CLEAN       = 3'd1,
    OUT_STALL_MAX   = 3'd2,
    OUT_STALL_MIN   = 3'd3,
    OUT_HW_FAULT    = 3'd4,
    OUT_UV_ABORT    = 3'd5,
    OUT_STALL_SKIP  = 3'd6
  } outcome_t;

  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_START_OC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OC_MAX     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_STALL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NO_STALL   = 2'd3;

  localparam logic [OC_W-1:0] OC_MAX_RESET = 5'd15;

endpackage

### src/driver_threshold_search_unit.sv
// Threshold search sequencer for a stepper driver's over-current and stall codes.
// Depends on dts_pkg for phase, outcome, request and register codes.
//
// Usage: configure the start codes, the over-current ceiling and the no-stall
// mode through the cfg_ write port while the unit is idle. Send a start request
// (in_tuser = 0) to load the start codes and enter the first phase, then one
// report request (in_tuser = 1) per test move, carrying the warning flags seen.
// Every request yields exactly one result carrying the codes to program, the
// phase after the step, a write flag and an outcome; out_tlast marks the result
// that ends or aborts the search (and any report sent while idle).
// The result is registered and shows in the cycle after its request. One request is
// taken every cycle while the receiver takes results: the search state and the
// result register update in the same edge, and that single register stage sets the rate.
// When the receiver stalls, the result register holds its item and the input
// side is still ready whenever that item is taken in the same cycle.
// Reset (synchronous, active low) empties the result register, sets the search
// idle with both codes at zero and restores the register defaults.
module driver_threshold_search_unit #(
  parameter int STALL_CODE_MAX = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [dts_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [dts_pkg::CFG_W-1:0]     cfg_wdata,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,  // over_current_seen, stall_seen, undervoltage_seen, 5'b0
  input  logic [0:0]  in_tuser,  // req_type
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // over_current_code[4:0], stall_code[11:5], phase[14:12], write_request[15],
  // outcome[18:16], zeros[23:19]
  output logic [23:0] out_tdata,
  output logic        out_tlast  // done_res
);

  localparam int StallCeilInt = (STALL_CODE_MAX > 127) ? 127 : STALL_CODE_MAX;
  localparam logic [dts_pkg::STALL_W-1:0] STALL_CEIL = dts_pkg::STALL_W'(StallCeilInt);

  // Configuration registers.
  logic [dts_pkg::OC_W-1:0]    start_oc_r;
  logic [dts_pkg::OC_W-1:0]    oc_max_r;
  logic [dts_pkg::STALL_W-1:0] start_stall_r;
  logic                        no_stall_r;

  // Search state.
  dts_pkg::phase_t             phase_r, phase_nxt;
  logic [dts_pkg::OC_W-1:0]    oc_r, oc_nxt;
  logic [dts_pkg::STALL_W-1:0] stall_r, stall_nxt;
  dts_pkg::outcome_t           outcome_nxt;

  // Result register.
  logic                        out_valid_r;
  logic [dts_pkg::OC_W-1:0]    res_oc_r;
  logic [dts_pkg::STALL_W-1:0] res_stall_r;
  dts_pkg::phase_t             res_phase_r;
  dts_pkg::outcome_t           res_outcome_r;

  logic in_accept;
  logic req_kind;
  logic oc_seen, stall_seen, uv_seen;

  assign req_kind   = in_tuser[0];
  assign oc_seen    = in_tdata[0];
  assign stall_seen = in_tdata[1];
  assign uv_seen    = in_tdata[2];

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_oc_r    <= '0;
      oc_max_r      <= dts_pkg::OC_MAX_RESET;
      start_stall_r <= '0;
      no_stall_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dts_pkg::REG_START_OC:    start_oc_r    <= cfg_wdata[dts_pkg::OC_W-1:0];
        dts_pkg::REG_OC_MAX:      oc_max_r      <= cfg_wdata[dts_pkg::OC_W-1:0];
        dts_pkg::REG_START_STALL: start_stall_r <= cfg_wdata[dts_pkg::STALL_W-1:0];
        dts_pkg::REG_NO_STALL:    no_stall_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    oc_nxt      = oc_r;
    stall_nxt   = stall_r;
    outcome_nxt = dts_pkg::OUT_RUNNING;
    if (req_kind == dts_pkg::REQ_START) begin
      oc_nxt    = start_oc_r;
      stall_nxt = start_stall_r;
      phase_nxt = dts_pkg::PH_OC_DOWN;
    end else if (phase_r != dts_pkg::PH_IDLE) begin
      if (uv_seen) begin
        phase_nxt   = dts_pkg::PH_IDLE;
        outcome_nxt = dts_pkg::OUT_UV_ABORT;
      end else if (phase_r == dts_pkg::PH_OC_DOWN || phase_r == dts_pkg::PH_OC_UP) begin
        // A stall warning alone does not count in the over-current phases.
        if (oc_seen) begin
          if (oc_r >= oc_max_r) begin
            oc_nxt    = oc_max_r;
            phase_nxt = dts_pkg::PH_STALL_DOWN;
          end else begin
            oc_nxt    = oc_r + dts_pkg::OC_W'(1);
            phase_nxt = dts_pkg::PH_OC_UP;
          end
        end else if (phase_r == dts_pkg::PH_OC_UP) begin
          phase_nxt = dts_pkg::PH_STALL_DOWN;
        end else if (oc_r != '0) begin
          oc_nxt = oc_r - dts_pkg::OC_W'(1);
        end else begin
          phase_nxt = dts_pkg::PH_STALL_DOWN;
        end
      end else begin
        if (no_stall_r) begin
          phase_nxt   = dts_pkg::PH_IDLE;
          outcome_nxt = dts_pkg::OUT_STALL_SKIP;
        end else if (stall_seen) begin
          if (stall_r >= STALL_CEIL) begin
            stall_nxt   = STALL_CEIL;
            phase_nxt   = dts_pkg::PH_IDLE;
            outcome_nxt = dts_pkg::OUT_STALL_MAX;
          end else begin
            stall_nxt = stall_r + dts_pkg::STALL_W'(1);
            phase_nxt = dts_pkg::PH_STALL_UP;
          end
        end else if (phase_r == dts_pkg::PH_STALL_DOWN) begin
          if (stall_r != '0) begin
            stall_nxt = stall_r - dts_pkg::STALL_W'(1);
          end else begin
            phase_nxt   = dts_pkg::PH_IDLE;
            outcome_nxt = dts_pkg::OUT_STALL_MIN;
          end
        end else begin
          // Over-current with the stall warning cleared points at a driver fault; else the search ends clean.
          phase_nxt   = dts_pkg::PH_IDLE;
          outcome_nxt = oc_seen ? dts_pkg::OUT_HW_FAULT : dts_pkg::OUT_CLEAN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dts_pkg::PH_IDLE;
      oc_r        <= '0;
      stall_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r     <= phase_nxt;
        oc_r        <= oc_nxt;
        stall_r     <= stall_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_oc_r      <= oc_nxt;
      res_stall_r   <= stall_nxt;
      res_phase_r   <= phase_nxt;
      res_outcome_r <= outcome_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = (res_phase_r == dts_pkg::PH_IDLE);
  assign out_tdata  = {5'b0, res_outcome_r, (res_phase_r != dts_pkg::PH_IDLE),
                       res_phase_r, res_stall_r, res_oc_r};

  // Every accepted request shows up as a result in the next cycle.
  a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_tvalid)
    else $error("accepted request produced no result");

  a_start_enters_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && req_kind == dts_pkg::REQ_START) |=>
      (res_phase_r == dts_pkg::PH_OC_DOWN && res_outcome_r == dts_pkg::OUT_RUNNING))
    else $error("start request did not enter the first phase");

  a_idle_report_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && req_kind == dts_pkg::REQ_REPORT && phase_r == dts_pkg::PH_IDLE) |=>
      (out_tlast && res_outcome_r == dts_pkg::OUT_RUNNING && $stable(oc_r)))
    else $error("report while idle changed the search");

  a_uv_aborts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && req_kind == dts_pkg::REQ_REPORT && uv_seen &&
     phase_r != dts_pkg::PH_IDLE) |=>
      (out_tlast && res_outcome_r == dts_pkg::OUT_UV_ABORT && $stable(stall_r)))
    else $error("undervoltage did not abort the search");

endmodule

### tb/testbench.sv
// Self-checking testbench for driver_threshold_search_unit.
// Tracks the search state per accepted request, compares every result field by field,
// and runs directed steps followed by random searches; depends on dts_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_CODE_LIMIT = 127;
  localparam int RANDOM_REQUESTS  = 900;
  localparam int ROUND_REQUESTS   = 70;
  localparam int LONG_HOLD        = 300;
  localparam int DRAIN_CYCLES     = 3;
  localparam int LIMIT_NS         = 1_000_000;

  typedef struct {
    logic [4:0]        oc_code;
    logic [6:0]        stall_code;
    dts_pkg::phase_t   phase;
    logic              write_req;
    logic              done;
    dts_pkg::outcome_t outcome;
  } step_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_PATTERN, SINK_TIGHT} sink_mode_t;

  class search_scoreboard;
    logic [4:0]      start_oc;
    logic [4:0]      oc_ceiling;
    logic [6:0]      start_stall;
    logic            no_stall;
    dts_pkg::phase_t phase;
    logic [4:0]      oc_code;
    logic [6:0]      stall_code;
    step_t           awaited[$];
    int              mismatches;
    int              steps_checked;

    function new();
      start_oc      = '0;
      oc_ceiling    = dts_pkg::OC_MAX_RESET;
      start_stall   = '0;
      no_stall      = 1'b0;
      phase         = dts_pkg::PH_IDLE;
      oc_code       = '0;
      stall_code    = '0;
      mismatches    = 0;
      steps_checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] value);
      case (idx)
        dts_pkg::REG_START_OC:    start_oc    = value[4:0];
        dts_pkg::REG_OC_MAX:      oc_ceiling  = value[4:0];
        dts_pkg::REG_START_STALL: start_stall = value;
        dts_pkg::REG_NO_STALL:    no_stall    = value[0];
        default: ;
      endcase
    endfunction

    // Advances the search by one accepted request and queues the result it must produce.
    function void note_request(logic kind, logic oc_seen, logic st_seen, logic uv_seen);
      step_t             want;
      dts_pkg::outcome_t result_code;
      logic [6:0]        stall_top;
      result_code = dts_pkg::OUT_RUNNING;
      stall_top   = (STALL_CODE_LIMIT > 127) ? 7'd127 : 7'(STALL_CODE_LIMIT);
      if (kind == dts_pkg::REQ_START) begin
        oc_code    = start_oc;
        stall_code = start_stall;
        phase      = dts_pkg::PH_OC_DOWN;
      end else if (phase != dts_pkg::PH_IDLE) begin
        if (uv_seen) begin
          phase       = dts_pkg::PH_IDLE;
          result_code = dts_pkg::OUT_UV_ABORT;
        end else if (phase == dts_pkg::PH_OC_DOWN || phase == dts_pkg::PH_OC_UP) begin
          // A stall warning alone does not count in the over-current phases.
          if (oc_seen) begin
            if (oc_code >= oc_ceiling) begin
              oc_code = oc_ceiling;
              phase   = dts_pkg::PH_STALL_DOWN;
            end else begin
              oc_code = oc_code + 5'd1;
              phase   = dts_pkg::PH_OC_UP;
            end
          end else if (phase == dts_pkg::PH_OC_UP) begin
            phase = dts_pkg::PH_STALL_DOWN;
          end else if (oc_code != 0) begin
            oc_code = oc_code - 5'd1;
          end else begin
            phase = dts_pkg::PH_STALL_DOWN;
          end
        end else if (no_stall) begin
          phase       = dts_pkg::PH_IDLE;
          result_code = dts_pkg::OUT_STALL_SKIP;
        end else if (st_seen) begin
          if (stall_code >= stall_top) begin
            stall_code  = stall_top;
            phase       = dts_pkg::PH_IDLE;
            result_code = dts_pkg::OUT_STALL_MAX;
          end else begin
            stall_code = stall_code + 7'd1;
            phase      = dts_pkg::PH_STALL_UP;
          end
        end else if (phase == dts_pkg::PH_STALL_DOWN) begin
          if (stall_code != 0) begin
            stall_code = stall_code - 7'd1;
          end else begin
            phase       = dts_pkg::PH_IDLE;
            result_code = dts_pkg::OUT_STALL_MIN;
          end
        end else begin
          phase       = dts_pkg::PH_IDLE;
          result_code = oc_seen ? dts_pkg::OUT_HW_FAULT : dts_pkg::OUT_CLEAN;
        end
      end
      want.oc_code    = oc_code;
      want.stall_code = stall_code;
      want.phase      = phase;
      want.write_req  = (phase != dts_pkg::PH_IDLE);
      want.done       = (phase == dts_pkg::PH_IDLE);
      want.outcome    = result_code;
      awaited.push_back(want);
    endfunction

    function void check_result(logic [23:0] data, logic last);
      step_t want;
      logic  bad;
      steps_checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request pending: data=%h last=%b",
                   $time, data, last);
        return;
      end
      want = awaited.pop_front();
      bad = (data[4:0] !== want.oc_code) || (data[11:5] !== want.stall_code) ||
            (data[14:12] !== want.phase) || (data[15] !== want.write_req) ||
            (data[18:16] !== want.outcome) || (data[23:19] !== 5'b0) ||
            (last !== want.done);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: step mismatch: expected oc=%0d stall=%0d phase=%0d wr=%0b",
                   $time, want.oc_code, want.stall_code, want.phase, want.write_req);
          $display("%0t:   expected done=%0b out=%0d", $time, want.done, want.outcome);
          $display("%0t:   got oc=%0d stall=%0d phase=%0d wr=%0b",
                   $time, data[4:0], data[11:5], data[14:12], data[15]);
          $display("%0t:   got done=%0b out=%0d pad=%h",
                   $time, last, data[18:16], data[23:19]);
        end
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_addr   = '0;
  logic [6:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;

  search_scoreboard sb;
  int requests_sent = 0;
  int burst_left    = 0;
  bit hold_off_req  = 1'b0;

  driver_threshold_search_unit #(
    .STALL_CODE_MAX(STALL_CODE_LIMIT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_request(in_tuser[0], in_tdata[0], in_tdata[1], in_tdata[2]);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tlast);
  end

  // flags are {undervoltage, stall, over-current}.
  task automatic send_item(input logic kind, input logic [2:0] flags);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'b0, flags};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.steps_checked < requests_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [6:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  // sel picks which of the four registers get written, lowest bit first.
  task automatic program_regs(input logic [3:0] sel, input logic [4:0] soc,
                              input logic [4:0] oc_top, input logic [6:0] sst, input logic ns);
    if (sel[0]) put_reg(dts_pkg::REG_START_OC, 7'(soc));
    if (sel[1]) put_reg(dts_pkg::REG_OC_MAX, 7'(oc_top));
    if (sel[2]) put_reg(dts_pkg::REG_START_STALL, sst);
    if (sel[3]) put_reg(dts_pkg::REG_NO_STALL, 7'(ns));
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_code(int top);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return top;
      2:       return $urandom_range(top - 8, top);
      default: return $urandom_range(0, top);
    endcase
  endfunction

  initial begin : result_sink
    sink_mode_t mode;
    int span;
    int tick;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        // Long back-pressure so the result register fills and the input side stalls.
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = sink_mode_t'($urandom_range(0, 3));
      span = $urandom_range(4, 48);
      repeat (span) begin
        case (mode)
          SINK_OPEN:    out_tready <= 1'b1;
          SINK_COIN:    out_tready <= 1'($urandom_range(0, 1));
          SINK_PATTERN: out_tready <= (tick % 4) != 3;
          default:      out_tready <= ($urandom_range(0, 5) == 0);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int round;
    int base;
    int round_base;
    int len;
    int p_oc;
    int p_st;
    logic oc_f;
    logic st_f;
    logic uv_f;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults straight out of reset, including a report while idle.
    send_item(dts_pkg::REQ_REPORT, 3'b111);
    send_item(dts_pkg::REQ_START, 3'b000);
    send_item(dts_pkg::REQ_REPORT, 3'b001);
    drain();

    program_regs(4'b1111, 5'd3, 5'd4, 7'd2, 1'b0);
    send_item(dts_pkg::REQ_START, 3'b111);
    send_item(dts_pkg::REQ_REPORT, 3'b010);  // stall warning alone still lowers the code
    send_item(dts_pkg::REQ_REPORT, 3'b001);
    send_item(dts_pkg::REQ_REPORT, 3'b001);
    send_item(dts_pkg::REQ_REPORT, 3'b001);  // reaches the ceiling, moves to the stall search
    send_item(dts_pkg::REQ_REPORT, 3'b000);
    send_item(dts_pkg::REQ_REPORT, 3'b010);
    send_item(dts_pkg::REQ_REPORT, 3'b001);  // over-current without stall while raising: fault
    send_item(dts_pkg::REQ_START, 3'b000);
    send_item(dts_pkg::REQ_REPORT, 3'b001);
    send_item(dts_pkg::REQ_REPORT, 3'b000);  // warning cleared while raising
    send_item(dts_pkg::REQ_REPORT, 3'b100);
    drain();

    // Start code above the ceiling and stall code at its top.
    program_regs(4'b1111, 5'd31, 5'd0, 7'd127, 1'b0);
    send_item(dts_pkg::REQ_START, 3'b000);
    send_item(dts_pkg::REQ_REPORT, 3'b001);
    send_item(dts_pkg::REQ_REPORT, 3'b010);
    send_item(dts_pkg::REQ_START, 3'b000);
    send_item(dts_pkg::REQ_REPORT, 3'b000);
    send_item(dts_pkg::REQ_START, 3'b000);   // restart in the middle of a search
    drain();

    program_regs(4'b1111, 5'd0, 5'd31, 7'd0, 1'b1);
    send_item(dts_pkg::REQ_START, 3'b000);
    send_item(dts_pkg::REQ_REPORT, 3'b000);
    send_item(dts_pkg::REQ_REPORT, 3'b010);
    drain();

    program_regs(4'b1000, 5'd0, 5'd0, 7'd0, 1'b0);
    send_item(dts_pkg::REQ_START, 3'b000);
    send_item(dts_pkg::REQ_REPORT, 3'b000);
    send_item(dts_pkg::REQ_REPORT, 3'b000);  // stall code already at zero with no warning
    send_item(dts_pkg::REQ_START, 3'b000);
    send_item(dts_pkg::REQ_REPORT, 3'b000);
    send_item(dts_pkg::REQ_REPORT, 3'b010);
    send_item(dts_pkg::REQ_REPORT, 3'b000);

    base  = requests_sent;
    round = 0;
    while (requests_sent - base < RANDOM_REQUESTS) begin
      drain();
      program_regs((round < 2) ? 4'hF : 4'($urandom_range(1, 15)),
                   5'(pick_code(31)), 5'(pick_code(31)), 7'(pick_code(127)),
                   ($urandom_range(0, 3) == 0));
      if (round == 2) hold_off_req = 1'b1;
      round_base = requests_sent;
      while (requests_sent - round_base < ROUND_REQUESTS) begin
        if ($urandom_range(0, 9) < 8) begin
          // A whole search with warnings drawn at per-search rates.
          send_item(dts_pkg::REQ_START, 3'($urandom_range(0, 7)));
          p_oc = $urandom_range(0, 8);
          p_st = $urandom_range(0, 8);
          len  = $urandom_range(1, 60);
          repeat (len) begin
            oc_f = ($urandom_range(0, 7) < p_oc);
            st_f = ($urandom_range(0, 7) < p_st);
            uv_f = ($urandom_range(0, 59) == 0);
            send_item(dts_pkg::REQ_REPORT, {uv_f, st_f, oc_f});
          end
        end else begin
          repeat ($urandom_range(1, 6))
            send_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        end
      end
      round++;
    end

    drain();
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
src/dts_pkg.sv
src/driver_threshold_search_unit.sv
tb/testbench.sv
